// ===== rtl/tnrp_pkg.sv =====
// Shared types, byte codes and reply tables for the telnet 5250 receive parser.
package tnrp_pkg;

  // Telnet command bytes.
  localparam logic [7:0] B_IAC  = 8'hFF;
  localparam logic [7:0] B_DONT = 8'hFE;
  localparam logic [7:0] B_DO   = 8'hFD;
  localparam logic [7:0] B_WONT = 8'hFC;
  localparam logic [7:0] B_WILL = 8'hFB;
  localparam logic [7:0] B_SB   = 8'hFA;
  localparam logic [7:0] B_GA   = 8'hF9;
  localparam logic [7:0] B_SE   = 8'hF0;
  localparam logic [7:0] B_EOR  = 8'hEF;

  // Telnet option codes.
  localparam logic [7:0] OPT_BINARY = 8'd0;
  localparam logic [7:0] OPT_SGA    = 8'd3;
  localparam logic [7:0] OPT_TTYPE  = 8'd24;
  localparam logic [7:0] OPT_EOR    = 8'd25;
  localparam logic [7:0] OPT_ENV    = 8'd39;

  // Subnegotiation and GDS header constants.
  localparam logic [7:0] SUB_SEND     = 8'h01;
  localparam logic [7:0] GDS_FLAGS_A0 = 8'hA0;

  // Option flag bit positions.
  localparam int FLAG_DOBIN = 0;
  localparam int FLAG_DOEOR = 1;
  localparam int FLAG_DOTT  = 2;
  localparam int FLAG_TTIS  = 3;
  localparam int FLAG_ENV   = 4;

  // Configuration register indexes.
  localparam logic [1:0] REG_LARGE_SCREEN = 2'd0;
  localparam logic [1:0] REG_DEVICE_NAME  = 2'd1;
  localparam logic [1:0] REG_RECORD_TYPE  = 2'd2;

  // Command queue geometry.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Fixed reply lengths and positions.
  localparam logic [4:0] TT_NAME_SMALL = 5'd11;
  localparam logic [4:0] TT_NAME_LARGE = 5'd13;
  localparam logic [4:0] ENV_PREFIX_LEN = 5'd13;
  localparam logic [4:0] ENV_NAME_POS   = 5'd13;
  localparam logic [4:0] ENV_IAC_POS    = 5'd14;

  // Receive parser states.
  typedef enum logic [2:0] {
    PS_NORMAL,
    PS_IAC,
    PS_WILL,
    PS_WONT,
    PS_DO,
    PS_DONT,
    PS_SB,
    PS_SBIAC
  } ps_t;

  // Result word kinds.
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_MARK = 2'd1,
    KIND_TX   = 2'd2
  } kind_t;

  // Commands handed from the parser to the output sequencer.
  typedef enum logic [2:0] {
    OP_DATA,
    OP_MARK,
    OP_TX3,
    OP_TTYPE,
    OP_ENV
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] code;
    logic [7:0] data;
    logic       rend;
    logic       conn;
  } cmd_t;

  // Terminal type name; the short name is the first eleven bytes.
  function automatic logic [7:0] tname_byte(input logic [3:0] i);
    logic [7:0] b;
    case (i)
      4'd0:    b = 8'h49;
      4'd1:    b = 8'h42;
      4'd2:    b = 8'h4D;
      4'd3:    b = 8'h2D;
      4'd4:    b = 8'h33;
      4'd5:    b = 8'h34;
      4'd6:    b = 8'h37;
      4'd7:    b = 8'h37;
      4'd8:    b = 8'h2D;
      4'd9:    b = 8'h46;
      4'd10:   b = 8'h43;
      4'd11:   b = 8'h2D;
      4'd12:   b = 8'h32;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Start of the environment IS reply, up to the VALUE code.
  function automatic logic [7:0] env_prefix_byte(input logic [3:0] i);
    logic [7:0] b;
    case (i)
      4'd0:    b = B_IAC;
      4'd1:    b = B_SB;
      4'd2:    b = OPT_ENV;
      4'd3:    b = 8'h00;
      4'd4:    b = 8'h03;
      4'd5:    b = 8'h44;
      4'd6:    b = 8'h45;
      4'd7:    b = 8'h56;
      4'd8:    b = 8'h4E;
      4'd9:    b = 8'h41;
      4'd10:   b = 8'h4D;
      4'd11:   b = 8'h45;
      4'd12:   b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/tnrp_front.sv =====
// Telnet command parser: tracks protocol state and turns each byte into at most one command.
module tnrp_front
  import tnrp_pkg::*;
#(
  parameter int HEADER_LENGTH = 6
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  input  logic [7:0] record_type,
  output logic       cmd_push,
  output cmd_t       cmd
);

  localparam logic [15:0] HDR_LEN = 16'(HEADER_LENGTH);

  ps_t         pstate, pstate_next;
  logic [15:0] cnt, cnt_next;
  logic [7:0]  hdr [4];
  logic [7:0]  hdr_next [4];
  logic        blocked, blocked_next;
  logic [7:0]  sub [2];
  logic [7:0]  sub_next [2];
  logic [1:0]  sub_cnt, sub_cnt_next;
  logic [4:0]  flags, flags_next;
  logic        data_mode, data_mode_next;

  // Data byte framing results.
  logic [7:0]  hdr_eff [4];
  logic [15:0] cnt_inc;
  logic [15:0] hlen;
  logic        chk, hdr_ok, db_rend, db_block;

  // Record length framing for the incoming byte if it turns out to be data.
  always_comb begin
    hdr_eff = hdr;
    if (cnt < 16'd4) begin
      hdr_eff[cnt[1:0]] = rx_byte;
    end
    cnt_inc  = (cnt == 16'hFFFF) ? cnt : cnt + 16'd1;
    hlen     = {hdr_eff[0], hdr_eff[1]};
    chk      = !blocked && (cnt_inc >= HDR_LEN);
    hdr_ok   = (hdr_eff[2] == record_type) &&
               ((hdr_eff[3] == 8'h00) || (hdr_eff[3] == GDS_FLAGS_A0)) &&
               (hlen >= HDR_LEN);
    db_rend  = chk && hdr_ok && (cnt_inc == hlen);
    db_block = blocked || (chk && !hdr_ok);
  end

  // Parser next state and command selection.
  always_comb begin
    logic data_take;
    logic mark_take;
    logic opt_take;
    logic is_do;
    logic is_dont;
    logic is_will;
    data_take    = 1'b0;
    mark_take    = 1'b0;
    opt_take     = 1'b0;
    is_do        = (pstate == PS_DO);
    is_dont      = (pstate == PS_DONT);
    is_will      = (pstate == PS_WILL);
    pstate_next  = pstate;
    cnt_next     = cnt;
    hdr_next     = hdr;
    blocked_next = blocked;
    sub_next     = sub;
    sub_cnt_next = sub_cnt;
    flags_next   = flags;
    cmd_push     = 1'b0;
    cmd.op       = OP_DATA;
    cmd.code     = 8'h00;
    cmd.data     = rx_byte;
    cmd.rend     = 1'b0;

    case (pstate)
      PS_NORMAL: begin
        if (rx_byte == B_IAC) begin
          pstate_next = PS_IAC;
        end else begin
          data_take = 1'b1;
        end
      end
      PS_IAC: begin
        pstate_next = PS_NORMAL;
        if (rx_byte == B_IAC) begin
          data_take = 1'b1;
        end else if ((rx_byte == B_EOR) || (rx_byte == B_GA)) begin
          mark_take = 1'b1;
        end else if (rx_byte == B_WILL) begin
          pstate_next = PS_WILL;
        end else if (rx_byte == B_WONT) begin
          pstate_next = PS_WONT;
        end else if (rx_byte == B_DO) begin
          pstate_next = PS_DO;
        end else if (rx_byte == B_DONT) begin
          pstate_next = PS_DONT;
        end else if (rx_byte == B_SB) begin
          sub_cnt_next = 2'd0;
          sub_next[0]  = 8'h00;
          sub_next[1]  = 8'h00;
          pstate_next  = PS_SB;
        end
      end
      PS_WILL, PS_WONT, PS_DO, PS_DONT: begin
        opt_take    = 1'b1;
        pstate_next = PS_NORMAL;
      end
      PS_SB: begin
        if (rx_byte == B_IAC) begin
          pstate_next = PS_SBIAC;
        end else if (sub_cnt < 2'd2) begin
          sub_next[sub_cnt[0]] = rx_byte;
          sub_cnt_next         = sub_cnt + 2'd1;
        end
      end
      PS_SBIAC: begin
        if (rx_byte == B_SE) begin
          // Only SEND requests for terminal type or environment get a reply.
          if (sub_cnt == 2'd2 && sub[1] == SUB_SEND) begin
            if (sub[0] == OPT_TTYPE) begin
              flags_next[FLAG_DOTT] = 1'b1;
              flags_next[FLAG_TTIS] = 1'b1;
              cmd_push = 1'b1;
              cmd.op   = OP_TTYPE;
            end else if (sub[0] == OPT_ENV) begin
              cmd_push = 1'b1;
              cmd.op   = OP_ENV;
            end
          end
          sub_cnt_next = 2'd0;
          sub_next[0]  = 8'h00;
          sub_next[1]  = 8'h00;
          pstate_next  = PS_NORMAL;
        end else begin
          if (rx_byte == B_IAC && sub_cnt < 2'd2) begin
            sub_next[sub_cnt[0]] = rx_byte;
            sub_cnt_next         = sub_cnt + 2'd1;
          end
          pstate_next = PS_SB;
        end
      end
      default: begin
        pstate_next = PS_NORMAL;
      end
    endcase

    // A data byte goes out and may close a length-framed record.
    if (data_take) begin
      cmd_push = 1'b1;
      cmd.op   = OP_DATA;
      cmd.rend = db_rend;
      if (db_rend) begin
        cnt_next     = 16'd0;
        hdr_next     = '{default: 8'h00};
        blocked_next = 1'b0;
      end else begin
        cnt_next     = cnt_inc;
        hdr_next     = hdr_eff;
        blocked_next = db_block;
      end
    end

    // An end-of-record or go-ahead command marks the end only of a non-empty record.
    if (mark_take) begin
      if (cnt != 16'd0) begin
        cmd_push = 1'b1;
        cmd.op   = OP_MARK;
        cmd.data = 8'h00;
      end
      cnt_next     = 16'd0;
      hdr_next     = '{default: 8'h00};
      blocked_next = 1'b0;
    end

    // Option negotiation replies.
    if (opt_take) begin
      case (rx_byte)
        OPT_BINARY: begin
          if (is_do) begin
            flags_next[FLAG_DOBIN] = 1'b1;
          end else if (is_dont) begin
            flags_next[FLAG_DOBIN] = 1'b0;
          end
        end
        OPT_EOR: begin
          if (is_do) begin
            flags_next[FLAG_DOEOR] = 1'b1;
          end else if (is_dont) begin
            flags_next[FLAG_DOEOR] = 1'b0;
          end
        end
        OPT_TTYPE: begin
          if (is_do) begin
            flags_next[FLAG_DOTT] = 1'b1;
          end
        end
        OPT_SGA: begin
          flags_next = flags;
        end
        OPT_ENV: begin
          if (is_do && !flags[FLAG_ENV]) begin
            flags_next[FLAG_ENV] = 1'b1;
            cmd_push = 1'b1;
            cmd.op   = OP_TX3;
            cmd.code = B_WILL;
          end
        end
        default: begin
          if (is_do) begin
            cmd_push = 1'b1;
            cmd.op   = OP_TX3;
            cmd.code = B_WONT;
          end else if (is_will) begin
            cmd_push = 1'b1;
            cmd.op   = OP_TX3;
            cmd.code = B_DONT;
          end
        end
      endcase
    end

    // Data mode is entered once the needed options are agreed or a terminal type reply is queued, and stays set.
    data_mode_next = data_mode || flags_next[FLAG_TTIS] ||
                     (flags_next[FLAG_DOBIN] && flags_next[FLAG_DOEOR] &&
                      flags_next[FLAG_DOTT]);
    cmd.conn = data_mode_next;
    cmd_push = cmd_push && accept;
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pstate    <= PS_NORMAL;
      cnt       <= 16'd0;
      hdr       <= '{default: 8'h00};
      blocked   <= 1'b0;
      sub       <= '{default: 8'h00};
      sub_cnt   <= 2'd0;
      flags     <= 5'd0;
      data_mode <= 1'b0;
    end else if (accept) begin
      pstate    <= pstate_next;
      cnt       <= cnt_next;
      hdr       <= hdr_next;
      blocked   <= blocked_next;
      sub       <= sub_next;
      sub_cnt   <= sub_cnt_next;
      flags     <= flags_next;
      data_mode <= data_mode_next;
    end
  end

endmodule

// ===== rtl/tnrp_queue.sv =====
// Short command queue between the parser and the output sequencer.
module tnrp_queue
  import tnrp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  cmd_t wr_cmd,
  output logic full,
  input  logic rd,
  output logic rd_valid,
  output cmd_t rd_cmd
);

  cmd_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;
  logic              wr_en;
  logic              rd_en;

  assign full     = (count == (QPTR_W + 1)'(QDEPTH));
  assign rd_valid = (count != '0);
  assign wr_en    = wr && !full;
  assign rd_en    = rd && rd_valid;
  assign rd_cmd   = mem[rptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wptr] <= wr_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wptr <= wptr + 1'b1;
      end
      if (rd_en) begin
        rptr <= rptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/tnrp_back.sv =====
// Output sequencer: expands queued commands, one word per cycle unless stalled.
module tnrp_back
  import tnrp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  cmd_t        head,
  output logic        head_pop,
  input  logic        large_screen,
  input  logic [63:0] device_name,
  input  logic        out_pop,
  output logic        out_valid,
  output kind_t       out_kind,
  output logic [7:0]  out_value,
  output logic        out_rend,
  output logic        out_last,
  output logic        out_conn
);

  logic [4:0] idx;
  logic [2:0] ci;
  logic       esc_done;
  logic       advance;
  logic [4:0] tt_len;
  logic [4:0] idx_m4;
  logic [7:0] ch;
  kind_t      word_kind;
  logic [7:0] word_value;
  logic       word_rend;
  logic       word_last;
  logic       esc;

  assign advance  = head_valid && (!out_valid || out_pop);
  assign head_pop = advance && word_last;
  assign tt_len   = large_screen ? TT_NAME_LARGE : TT_NAME_SMALL;
  assign idx_m4   = idx - 5'd4;
  assign ch       = device_name[{~ci, 3'b000} +: 8];

  // Word at the current position of the head command.
  always_comb begin
    word_kind  = KIND_TX;
    word_value = 8'h00;
    word_rend  = 1'b0;
    word_last  = 1'b0;
    esc        = 1'b0;
    case (head.op)
      OP_DATA: begin
        word_kind  = KIND_DATA;
        word_value = head.data;
        word_rend  = head.rend;
        word_last  = 1'b1;
      end
      OP_MARK: begin
        word_kind = KIND_MARK;
        word_last = 1'b1;
      end
      OP_TX3: begin
        case (idx[1:0])
          2'd0:    word_value = B_IAC;
          2'd1:    word_value = head.code;
          default: word_value = head.data;
        endcase
        word_last = (idx == 5'd2);
      end
      OP_TTYPE: begin
        if (idx < 5'd4) begin
          case (idx[1:0])
            2'd0:    word_value = B_IAC;
            2'd1:    word_value = B_SB;
            2'd2:    word_value = OPT_TTYPE;
            default: word_value = 8'h00;
          endcase
        end else if (idx < tt_len + 5'd4) begin
          word_value = tname_byte(idx_m4[3:0]);
        end else if (idx == tt_len + 5'd4) begin
          word_value = B_IAC;
        end else begin
          word_value = B_SE;
          word_last  = 1'b1;
        end
      end
      OP_ENV: begin
        if (idx < ENV_PREFIX_LEN) begin
          word_value = env_prefix_byte(idx[3:0]);
        end else if (idx == ENV_NAME_POS) begin
          // A name byte of 0xFF goes out doubled.
          word_value = ch;
          esc        = (ch == B_IAC) && !esc_done;
        end else if (idx == ENV_IAC_POS) begin
          word_value = B_IAC;
        end else begin
          word_value = B_SE;
          word_last  = 1'b1;
        end
      end
      default: begin
        word_last = 1'b1;
      end
    endcase
  end

  // Position counters and output word valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 5'd0;
      ci        <= 3'd0;
      esc_done  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_pop) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        if (word_last) begin
          idx      <= 5'd0;
          ci       <= 3'd0;
          esc_done <= 1'b0;
        end else if (head.op == OP_ENV && idx == ENV_NAME_POS) begin
          if (esc) begin
            esc_done <= 1'b1;
          end else begin
            esc_done <= 1'b0;
            if (ci == 3'd7) begin
              idx <= ENV_IAC_POS;
            end else begin
              ci <= ci + 3'd1;
            end
          end
        end else begin
          idx <= idx + 5'd1;
        end
      end
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_kind  <= word_kind;
      out_value <= word_value;
      out_rend  <= word_rend;
      out_last  <= word_last;
      out_conn  <= head.conn;
    end
  end

endmodule

// ===== rtl/telnet_5250_receive_parser_top.sv =====
// Top level of the telnet 5250 receive parser: ports, configuration registers and checks.
// A received byte is taken on any cycle where full is low, so an unbroken stream of data
// bytes passes at one byte per cycle while results are popped, through the command queue
// and the output word register. The parser classifies each byte into at most one command
// and writes it into a four-entry command queue; the output sequencer reads that queue and
// sends one word per cycle while the result port is popped. A data byte gives one word and
// a reply one word per reply byte: three for an option reply, 17 or 19 for the terminal
// type reply, and 23 to 31 for the environment reply, depending on how many device name
// bytes are 0xFF. Full rises only once such replies have filled the queue or the result
// port is not being popped. The last word caused by a byte carries last, and connected
// shows data mode as it stood after that byte. Configuration writes are taken on any cycle
// and must be made while no results are pending. No clearing pass is needed after reset.
module telnet_5250_receive_parser_top
  import tnrp_pkg::*;
#(
  parameter int HEADER_LENGTH = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind,
  output logic [7:0]  value,
  output logic        record_end,
  output logic        last,
  output logic        connected,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic        large_screen;
  logic [63:0] device_name;
  logic [7:0]  record_type;
  logic        accept;
  logic        cmd_push;
  cmd_t        cmd;
  logic        head_valid;
  cmd_t        head;
  logic        head_pop;
  logic        out_valid;
  kind_t       out_kind;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;
  assign empty     = !out_valid;
  assign kind      = out_kind;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      large_screen <= 1'b0;
      device_name  <= 64'd6355577325046583345;
      record_type  <= 8'd18;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LARGE_SCREEN: large_screen <= cfg_data[0];
        REG_DEVICE_NAME:  device_name  <= cfg_data;
        REG_RECORD_TYPE:  record_type  <= cfg_data[7:0];
        default:          record_type  <= record_type;
      endcase
    end
  end

  tnrp_front #(
    .HEADER_LENGTH(HEADER_LENGTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .rx_byte     (rx_byte),
    .record_type (record_type),
    .cmd_push    (cmd_push),
    .cmd         (cmd)
  );

  tnrp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (cmd_push),
    .wr_cmd   (cmd),
    .full     (full),
    .rd       (head_pop),
    .rd_valid (head_valid),
    .rd_cmd   (head)
  );

  tnrp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .head_pop     (head_pop),
    .large_screen (large_screen),
    .device_name  (device_name),
    .out_pop      (pop),
    .out_valid    (out_valid),
    .out_kind     (out_kind),
    .out_value    (value),
    .out_rend     (record_end),
    .out_last     (last),
    .out_conn     (connected)
  );

  // An end marker carries no byte and never closes a length-framed record.
  a_mark_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_kind == KIND_MARK) |-> (value == 8'h00 && !record_end && last))
    else $error("end marker word carries data");

  // Only a data byte closes a length-framed record, and it is the only word of its byte.
  a_rend_data: assert property (@(posedge clk) disable iff (rst)
    (!empty && record_end) |-> (out_kind == KIND_DATA && last))
    else $error("record end flag on a word that is not a lone data byte");

  // Data mode, once shown as entered, stays entered on later words.
  a_conn_sticky: assert property (@(posedge clk) disable iff (rst)
    (!empty && $past(!empty) && $past(!rst) && $past(connected)) |-> connected)
    else $error("connected dropped after data mode was entered");

  // A byte offered while the queue is full is held off.
  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (push && full) |-> !cmd_push)
    else $error("command written while the queue is full");

endmodule

// ===== sim/tb_telnet_5250_receive_parser_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the telnet 5250 receive parser, with its own parser predictor.
module tb_telnet_5250_receive_parser_top;
  import tnrp_pkg::*;

  localparam int HDR_LEN      = 6;
  localparam int SETTLE       = 8;
  localparam int STALL_CYCLES = 300;
  localparam int LIMIT        = 600000;
  localparam int LONG_RECORD  = 20;

  // Codes that the parser does not know as commands, and subnegotiation codes.
  localparam logic [7:0] CMD_NOP   = 8'hF1;
  localparam logic [7:0] SUB_IS    = 8'h00;
  localparam logic [7:0] ENV_VAR   = 8'h03;
  localparam logic [7:0] ENV_VALUE = 8'h01;

  // Terminal type name; the 24x80 form is the first eleven bytes.
  localparam logic [103:0] TERM_NAME = 104'h49424D2D333437372D46432D32;
  // Environment variable name DEVNAME.
  localparam logic [55:0]  VAR_NAME  = 56'h444556_4E414D45;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
    logic       record_end;
    logic       last;
    logic       connected;
  } word_t;

  logic        clk;
  logic        rst       = 1'b1;
  logic        push      = 1'b0;
  logic        full;
  logic [7:0]  rx_byte   = 8'h00;
  logic        empty;
  logic        pop       = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  value;
  logic        record_end;
  logic        last;
  logic        connected;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_LARGE_SCREEN;
  logic [63:0] cfg_data  = 64'd0;

  // Predictor state and its copy of the registers.
  ps_t         parse_st   = PS_NORMAL;
  logic [15:0] rec_cnt    = 16'd0;
  logic [7:0]  hdr [4]    = '{default: 8'h00};
  logic        blocked    = 1'b0;
  logic [7:0]  sub_b [2]  = '{default: 8'h00};
  logic [1:0]  sub_cnt    = 2'd0;
  logic [4:0]  opt_flags  = 5'd0;
  logic        data_mode  = 1'b0;
  logic        big_screen = 1'b0;
  logic [63:0] dev_name   = 64'd6355577325046583345;
  logic [7:0]  rec_type   = 8'd18;

  logic [7:0]  line_bytes [$];
  word_t       want_words [$];
  word_t       burst [$];

  int errors     = 0;
  int n_bytes    = 0;
  int n_words    = 0;
  int n_rend     = 0;
  int n_mark     = 0;
  int n_tx       = 0;
  int cycles     = 0;
  int queued     = 0;
  int send_idle  = 0;
  int recv_idle  = 0;
  int stall_req  = 0;
  int stall_seen = 0;
  int stall_left = 0;

  telnet_5250_receive_parser_top #(.HEADER_LENGTH(HDR_LEN)) u_dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .rx_byte    (rx_byte),
    .empty      (empty),
    .pop        (pop),
    .kind       (kind),
    .value      (value),
    .record_end (record_end),
    .last       (last),
    .connected  (connected),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void add_word(kind_t k, logic [7:0] v, logic rend);
    word_t w;
    w.kind       = k;
    w.value      = v;
    w.record_end = rend;
    w.last       = 1'b0;
    w.connected  = 1'b0;
    burst.insert(burst.size(), w);
  endfunction

  function automatic void clear_record();
    rec_cnt = 16'd0;
    blocked = 1'b0;
    for (int i = 0; i < 4; i++) hdr[i] = 8'h00;
  endfunction

  // A record data byte: count it, check the GDS header once six bytes are in.
  function automatic void take_data(logic [7:0] b);
    logic        rend;
    logic [15:0] len;
    logic        ok;
    rend = 1'b0;
    if (rec_cnt < 16'd4) hdr[rec_cnt[1:0]] = b;
    if (rec_cnt != 16'hFFFF) rec_cnt = rec_cnt + 16'd1;
    if (!blocked && rec_cnt >= HDR_LEN) begin
      len = {hdr[0], hdr[1]};
      ok  = hdr[2] == rec_type && (hdr[3] == 8'h00 || hdr[3] == GDS_FLAGS_A0) &&
            len >= HDR_LEN;
      if (!ok) begin
        blocked = 1'b1;
      end else if (rec_cnt == len) begin
        rend = 1'b1;
      end
    end
    add_word(KIND_DATA, b, rend);
    if (rend) clear_record();
  endfunction

  // An EOR or GA marks the record end only when the record holds data.
  function automatic void end_record();
    if (rec_cnt != 16'd0) add_word(KIND_MARK, 8'h00, 1'b0);
    clear_record();
  endfunction

  function automatic void update_mode();
    if ((opt_flags[FLAG_DOBIN] && opt_flags[FLAG_DOEOR] && opt_flags[FLAG_DOTT]) ||
        opt_flags[FLAG_TTIS]) data_mode = 1'b1;
  endfunction

  function automatic void send3(logic [7:0] cmd, logic [7:0] opt);
    add_word(KIND_TX, B_IAC, 1'b0);
    add_word(KIND_TX, cmd, 1'b0);
    add_word(KIND_TX, opt, 1'b0);
  endfunction

  // Option requests: track what the host asked for and refuse unknown options.
  function automatic void option_request(logic [7:0] cmd, logic [7:0] opt);
    case (opt)
      OPT_BINARY: begin
        if (cmd == B_DO) opt_flags[FLAG_DOBIN] = 1'b1;
        else if (cmd == B_DONT) opt_flags[FLAG_DOBIN] = 1'b0;
      end
      OPT_EOR: begin
        if (cmd == B_DO) opt_flags[FLAG_DOEOR] = 1'b1;
        else if (cmd == B_DONT) opt_flags[FLAG_DOEOR] = 1'b0;
      end
      OPT_TTYPE: begin
        if (cmd == B_DO) opt_flags[FLAG_DOTT] = 1'b1;
      end
      OPT_SGA: begin
      end
      OPT_ENV: begin
        if (cmd == B_DO && !opt_flags[FLAG_ENV]) begin
          opt_flags[FLAG_ENV] = 1'b1;
          send3(B_WILL, OPT_ENV);
        end
      end
      default: begin
        if (cmd == B_DO) send3(B_WONT, opt);
        if (cmd == B_WILL) send3(B_DONT, opt);
      end
    endcase
    update_mode();
  endfunction

  function automatic void sub_store(logic [7:0] b);
    if (sub_cnt < 2'd2) begin
      sub_b[sub_cnt[0]] = b;
      sub_cnt = sub_cnt + 2'd1;
    end
  endfunction

  function automatic void sub_clear();
    sub_cnt  = 2'd0;
    sub_b[0] = 8'h00;
    sub_b[1] = 8'h00;
  endfunction

  // Answer a SEND for the terminal type or for the environment.
  function automatic void answer_subneg();
    int         n;
    logic [7:0] c;
    if (sub_cnt < 2'd2) return;
    if (sub_b[0] == OPT_TTYPE && sub_b[1] == SUB_SEND) begin
      n = big_screen ? 13 : 11;
      opt_flags[FLAG_DOTT] = 1'b1;
      add_word(KIND_TX, B_IAC, 1'b0);
      add_word(KIND_TX, B_SB, 1'b0);
      add_word(KIND_TX, OPT_TTYPE, 1'b0);
      add_word(KIND_TX, SUB_IS, 1'b0);
      for (int i = 0; i < n; i++) add_word(KIND_TX, TERM_NAME[103 - 8 * i -: 8], 1'b0);
      add_word(KIND_TX, B_IAC, 1'b0);
      add_word(KIND_TX, B_SE, 1'b0);
      opt_flags[FLAG_TTIS] = 1'b1;
      update_mode();
    end else if (sub_b[0] == OPT_ENV && sub_b[1] == SUB_SEND) begin
      add_word(KIND_TX, B_IAC, 1'b0);
      add_word(KIND_TX, B_SB, 1'b0);
      add_word(KIND_TX, OPT_ENV, 1'b0);
      add_word(KIND_TX, SUB_IS, 1'b0);
      add_word(KIND_TX, ENV_VAR, 1'b0);
      for (int i = 0; i < 7; i++) add_word(KIND_TX, VAR_NAME[55 - 8 * i -: 8], 1'b0);
      add_word(KIND_TX, ENV_VALUE, 1'b0);
      // Name bytes of 0xFF go out doubled.
      for (int i = 0; i < 8; i++) begin
        c = dev_name[63 - 8 * i -: 8];
        if (c == B_IAC) add_word(KIND_TX, B_IAC, 1'b0);
        add_word(KIND_TX, c, 1'b0);
      end
      add_word(KIND_TX, B_IAC, 1'b0);
      add_word(KIND_TX, B_SE, 1'b0);
    end
  endfunction

  // Step the telnet state machine by one received byte and queue its words.
  function automatic void parse_rx_byte(logic [7:0] b);
    word_t w;
    burst.delete();
    case (parse_st)
      PS_NORMAL: begin
        if (b == B_IAC) parse_st = PS_IAC;
        else take_data(b);
      end
      PS_IAC: begin
        parse_st = PS_NORMAL;
        if (b == B_IAC) take_data(b);
        else if (b == B_EOR || b == B_GA) end_record();
        else if (b == B_WILL) parse_st = PS_WILL;
        else if (b == B_WONT) parse_st = PS_WONT;
        else if (b == B_DO) parse_st = PS_DO;
        else if (b == B_DONT) parse_st = PS_DONT;
        else if (b == B_SB) begin
          sub_clear();
          parse_st = PS_SB;
        end
      end
      PS_WILL: begin
        option_request(B_WILL, b);
        parse_st = PS_NORMAL;
      end
      PS_WONT: begin
        option_request(B_WONT, b);
        parse_st = PS_NORMAL;
      end
      PS_DO: begin
        option_request(B_DO, b);
        parse_st = PS_NORMAL;
      end
      PS_DONT: begin
        option_request(B_DONT, b);
        parse_st = PS_NORMAL;
      end
      PS_SB: begin
        if (b == B_IAC) parse_st = PS_SBIAC;
        else sub_store(b);
      end
      default: begin
        if (b == B_SE) begin
          answer_subneg();
          sub_clear();
          parse_st = PS_NORMAL;
        end else begin
          if (b == B_IAC) sub_store(b);
          parse_st = PS_SB;
        end
      end
    endcase
    for (int k = 0; k < burst.size(); k++) begin
      w           = burst[k];
      w.last      = (k == burst.size() - 1);
      w.connected = data_mode;
      want_words.insert(want_words.size(), w);
    end
  endfunction

  // ---------------------------------------------------------------- driver and monitor

  // Offer the next pending byte; a byte refused while full stays on the port.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        parse_rx_byte(rx_byte);
        n_bytes++;
      end
      if (!(push && full)) begin
        if (line_bytes.size() != 0 && $urandom_range(99) >= send_idle) begin
          push    <= 1'b1;
          rx_byte <= line_bytes.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here once requested.
  always @(posedge clk) begin
    if (stall_seen != stall_req) begin
      stall_left <= STALL_CYCLES;
      stall_seen <= stall_req;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  // Compare each popped word with the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (want_words.size() == 0) begin
          $error("word with nothing expected: kind %0d value %0h", kind, value);
          errors++;
        end else begin
          check_field("kind", 8'(want_words[0].kind), 8'(kind));
          check_field("value", want_words[0].value, value);
          check_field("record_end", 8'(want_words[0].record_end), 8'(record_end));
          check_field("last", 8'(want_words[0].last), 8'(last));
          check_field("connected", 8'(want_words[0].connected), 8'(connected));
          void'(want_words.pop_front());
        end
        n_words++;
        if (kind == KIND_MARK) n_mark++;
        if (kind == KIND_TX) n_tx++;
        if (record_end) n_rend++;
      end
      pop <= (stall_left == 0) && ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $error("timeout after %0d cycles with %0d words outstanding", LIMIT, want_words.size());
      $display("telnet_5250_receive_parser_top regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic put(input logic [7:0] b);
    line_bytes.insert(line_bytes.size(), b);
    queued++;
  endtask

  // A data byte on the line; 0xFF must be doubled.
  task automatic put_data(input logic [7:0] b);
    if (b == B_IAC) put(B_IAC);
    put(b);
  endtask

  task automatic put_cmd(input logic [7:0] c);
    put(B_IAC);
    put(c);
  endtask

  // Write a register word, leaving valid high for the next one.
  task automatic cfg_word(input logic [1:0] idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_registers(input logic ls, input logic [63:0] dn, input logic [7:0] rt);
    cfg_word(REG_LARGE_SCREEN, {63'd0, ls});
    cfg_word(REG_DEVICE_NAME, dn);
    cfg_word(REG_RECORD_TYPE, {56'd0, rt});
    cfg_valid  <= 1'b0;
    big_screen = ls;
    dev_name   = dn;
    rec_type   = rt;
  endtask

  // Wait until every byte is taken and every expected word has come out.
  task automatic drain();
    while (line_bytes.size() != 0 || push || want_words.size() != 0 || stall_left != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Mostly well-formed telnet traffic with random content, some noise.
  task automatic gen_random(input int target);
    int         start;
    int         sel;
    int         len;
    logic [7:0] cmd;
    logic [7:0] opt;
    start = queued;
    while (queued - start < target) begin
      sel = $urandom_range(99);
      if (sel < 30) begin
        repeat ($urandom_range(1, 6)) put_data(8'($urandom));
      end else if (sel < 55) begin
        // GDS record with a mostly valid header.
        len = $urandom_range(HDR_LEN, 12);
        if ($urandom_range(9) == 0) begin
          put_data(8'($urandom));
          put_data(8'($urandom));
        end else begin
          put_data(8'h00);
          put_data(8'(len));
        end
        put_data(($urandom_range(9) == 0) ? 8'($urandom) : rec_type);
        if ($urandom_range(9) == 0) put_data(8'($urandom));
        else put_data($urandom_range(1) ? GDS_FLAGS_A0 : 8'h00);
        repeat (len - 4) put_data(8'($urandom));
        if ($urandom_range(3) == 0) put_cmd(B_EOR);
      end else if (sel < 65) begin
        put_cmd($urandom_range(1) ? B_EOR : B_GA);
      end else if (sel < 80) begin
        case ($urandom_range(3))
          0: cmd = B_WILL;
          1: cmd = B_WONT;
          2: cmd = B_DO;
          default: cmd = B_DONT;
        endcase
        case ($urandom_range(6))
          0: opt = OPT_BINARY;
          1: opt = OPT_SGA;
          2: opt = OPT_TTYPE;
          3: opt = OPT_EOR;
          4: opt = OPT_ENV;
          5: opt = B_IAC;
          default: opt = 8'($urandom);
        endcase
        put_cmd(cmd);
        put(opt);
      end else if (sel < 92) begin
        // Subnegotiation, sometimes short or with a stray command inside.
        case ($urandom_range(2))
          0: opt = OPT_TTYPE;
          1: opt = OPT_ENV;
          default: opt = 8'($urandom);
        endcase
        len = $urandom_range(9);
        put_cmd(B_SB);
        if (len >= 1) put_data(opt);
        if (len >= 2) put_data(($urandom_range(4) == 0) ? 8'($urandom) : SUB_SEND);
        if (len >= 8) begin
          put_data(8'($urandom));
          put_cmd(8'($urandom_range(0, 8'hEE)));
        end
        put_cmd(B_SE);
      end else begin
        if ($urandom_range(1)) put(8'($urandom));
        else put_cmd(8'($urandom_range(0, 8'hEE)));
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Busy sender, slow receiver; directed cases first.
    send_idle <= 11;
    recv_idle <= 68;
    set_registers(1'b0, {8'hFF, 24'($urandom), 32'($urandom)}, 8'h12);
    put_data(8'h00);
    put_data(B_IAC);
    put_data(8'h41);
    put_cmd(B_EOR);
    put_cmd(B_GA);
    put_cmd(CMD_NOP);
    put_cmd(B_DO);
    put(B_IAC);
    put_cmd(B_DO);
    put(OPT_ENV);
    put_cmd(B_SB);
    put(OPT_TTYPE);
    put(SUB_SEND);
    put_cmd(B_SE);
    put_cmd(B_SB);
    put(OPT_ENV);
    put(SUB_SEND);
    put_cmd(B_SE);
    put_data(8'h00);
    put_data(8'(HDR_LEN));
    put_data(rec_type);
    put_data(GDS_FLAGS_A0);
    put_data(8'h55);
    put_data(8'h66);
    gen_random(70);
    drain();

    // Slow sender, busy receiver, with a long hold-off so the input backs up.
    send_idle <= 68;
    recv_idle <= 11;
    set_registers(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
    stall_req <= stall_req + 1;
    gen_random(70);
    drain();

    // No idling; a record whose header does not match runs past its stated length.
    send_idle <= 0;
    recv_idle <= 0;
    set_registers(1'b0, 64'd0, 8'h00);
    put(8'h00);
    put_cmd(B_EOR);
    put_data(8'h00);
    put_data(8'h08);
    put_data(8'h55);
    put_data(8'h00);
    repeat (LONG_RECORD - 4) put_data(8'($urandom_range(0, 8'hFE)));
    put_cmd(B_EOR);
    gen_random(70);
    drain();

    $display("Run covered %0d received bytes and %0d checked words in %0d cycles.",
             n_bytes, n_words, cycles);
    $display("Words seen: %0d framed record ends, %0d end markers, %0d transmit bytes.",
             n_rend, n_mark, n_tx);
    if (errors == 0) begin
      $display("telnet_5250_receive_parser_top regression: pass");
    end else begin
      $display("telnet_5250_receive_parser_top regression: fail");
    end
    $finish;
  end

endmodule
